// ===== rtl/tgle_pkg.sv =====
package tgle_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int NUM_GLYPHS = 95;

	localparam logic [7:0] CODE_TAB         = 8'h09;
	localparam logic [7:0] CODE_NEWLINE     = 8'h0A;
	localparam logic [7:0] CODE_SPACE       = 8'h20;
	localparam logic [7:0] CODE_FIRST_GLYPH = 8'h21;
	localparam logic [7:0] CODE_LAST_GLYPH  = 8'h7F;
	localparam logic [6:0] INVALID_GLYPH    = 7'd94;
	localparam logic [3:0] GLYPH_HEIGHT     = 4'd9;

	typedef enum logic [0:0] {
		CMD_GLYPH = 1'b0,
		CMD_PAGE  = 1'b1
	} cmd_kind_t;

	typedef enum logic [2:0] {
		CFG_SHEET_U       = 3'd0,
		CFG_SHEET_V       = 3'd1,
		CFG_PALETTE_ID    = 3'd2,
		CFG_TEXTURE_PAGE  = 3'd3,
		CFG_TAB_STOP_LOG2 = 3'd4,
		CFG_LINE_STEP     = 3'd5,
		CFG_BLANK_STEP    = 3'd6
	} cfg_idx_t;

	typedef enum logic [1:0] {
		CLS_TAB,
		CLS_NEWLINE,
		CLS_SPACE,
		CLS_GLYPH
	} char_class_t;

	typedef struct packed {
		logic [7:0]  sheet_u;
		logic [7:0]  sheet_v;
		logic [15:0] palette_id;
		logic [15:0] texture_page;
		logic [2:0]  tab_stop_log2;
		logic [7:0]  line_step;
		logic [7:0]  blank_step;
	} cfg_t;

	typedef struct packed {
		logic [7:0]         char_code;
		logic               first_char;
		logic signed [15:0] origin_x;
		logic signed [15:0] origin_y;
		logic [15:0]        depth_slot;
		logic               last_char;
	} char_item_t;

	typedef struct packed {
		logic               cmd_kind;
		logic signed [15:0] screen_x;
		logic signed [15:0] screen_y;
		logic [7:0]         tex_u;
		logic [7:0]         tex_v;
		logic [15:0]        clut_word;
		logic [2:0]         glyph_width;
		logic [3:0]         glyph_height;
		logic [15:0]        page_word;
		logic [15:0]        slot_tag;
		logic               run_end;
	} glyph_item_t;

	// one queued work entry: an optional rectangle, an optional texpage
	typedef struct packed {
		logic               has_glyph;
		logic               has_page;
		logic signed [15:0] screen_x;
		logic signed [15:0] screen_y;
		logic [7:0]         tex_u;
		logic [7:0]         tex_v;
		logic [2:0]         glyph_width;
		logic [15:0]        slot_tag;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	localparam logic [2:0] GLYPH_W [NUM_GLYPHS] = '{
		3'd2, 3'd4, 3'd6, 3'd6, 3'd6, 3'd6, 3'd2, 3'd3, 3'd3, 3'd4, 3'd6, 3'd3, 3'd6, 3'd2,
		3'd6,
		3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6,
		3'd2, 3'd3, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6,
		3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd4, 3'd5,
		3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6,
		3'd6, 3'd6,
		3'd3, 3'd6, 3'd3, 3'd4, 3'd6, 3'd3,
		3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd5, 3'd6, 3'd5, 3'd2, 3'd4, 3'd5, 3'd2, 3'd6,
		3'd5, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd5, 3'd5, 3'd6, 3'd6, 3'd6, 3'd6, 3'd5,
		3'd4, 3'd2, 3'd4, 3'd6,
		3'd6
	};

	function automatic char_class_t classify(input logic [7:0] code);
		char_class_t cls;
		priority case (code)
			CODE_TAB:     cls = CLS_TAB;
			CODE_NEWLINE: cls = CLS_NEWLINE;
			CODE_SPACE:   cls = CLS_SPACE;
			default:      cls = CLS_GLYPH;
		endcase
		return cls;
	endfunction

	// high codes and stray control codes fall back to the invalid glyph
	function automatic logic [6:0] glyph_index(input logic [7:0] code);
		logic [7:0] off;
		off = code - CODE_FIRST_GLYPH;
		if (code >= CODE_FIRST_GLYPH && code <= CODE_LAST_GLYPH)
			return off[6:0];
		return INVALID_GLYPH;
	endfunction

endpackage

// ===== rtl/tgle_stream_if.sv =====
interface tgle_char_if;
	import tgle_pkg::*;

	logic       valid;
	logic       ready;
	char_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tgle_glyph_if;
	import tgle_pkg::*;

	logic        valid;
	logic        ready;
	glyph_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/tgle_front.sv =====
module tgle_front (
	input  logic                clk,
	input  logic                arst_n,
	input  tgle_pkg::cfg_t      cfg,
	input  logic                in_valid,
	input  tgle_pkg::char_item_t in_data,
	output logic                in_ready,
	input  tgle_pkg::q_stat_t   q_stat,
	output logic                push,
	output tgle_pkg::q_entry_t  push_entry
);
	import tgle_pkg::*;

	logic [15:0] cursor_x_q, cursor_y_q, line_start_x_q;
	logic [15:0] cx, cy, lsx;
	logic [15:0] span_m1, cx_next, cy_next;
	logic        accept;
	char_class_t cls;
	logic [6:0]  gidx, gpos;
	logic [6:0]  gx;
	logic [5:0]  gy;
	logic [2:0]  gw;

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;

	// cursor as seen by this character
	assign cx  = in_data.first_char ? in_data.origin_x : cursor_x_q;
	assign cy  = in_data.first_char ? in_data.origin_y : cursor_y_q;
	assign lsx = in_data.first_char ? in_data.origin_x : line_start_x_q;

	assign cls  = classify(in_data.char_code);
	assign gidx = glyph_index(in_data.char_code);
	assign gpos = gidx + 7'd1;
	assign gx   = {3'd0, gpos[3:0]} * 7'd6;
	assign gy   = {3'd0, gpos[6:4]} * 6'd9;
	assign gw   = GLYPH_W[gidx];

	assign span_m1 = (16'd1 << cfg.tab_stop_log2) - 16'd1;

	always_comb begin
		cx_next = cx;
		cy_next = cy;
		unique case (cls)
			CLS_TAB:     cx_next = (cx + span_m1) & ~span_m1;
			CLS_NEWLINE: begin
				cx_next = lsx;
				cy_next = cy + {8'd0, cfg.line_step};
			end
			CLS_SPACE:   cx_next = cx + {8'd0, cfg.blank_step};
			CLS_GLYPH:   cx_next = cx + {13'd0, gw};
			default:     cx_next = cx;
		endcase
	end

	assign push = accept && ((cls == CLS_GLYPH) || in_data.last_char);

	always_comb begin
		push_entry.has_glyph   = (cls == CLS_GLYPH);
		push_entry.has_page    = in_data.last_char;
		push_entry.screen_x    = cx;
		push_entry.screen_y    = cy;
		push_entry.tex_u       = cfg.sheet_u + {1'b0, gx};
		push_entry.tex_v       = cfg.sheet_v + {2'b0, gy};
		push_entry.glyph_width = gw;
		push_entry.slot_tag    = in_data.depth_slot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q     <= '0;
			cursor_y_q     <= '0;
			line_start_x_q <= '0;
		end else if (accept) begin
			cursor_x_q     <= cx_next;
			cursor_y_q     <= cy_next;
			line_start_x_q <= lsx;
		end
	end
endmodule

// ===== rtl/tgle_queue.sv =====
module tgle_queue #(
	parameter int DEPTH = tgle_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  tgle_pkg::q_entry_t push_entry,
	input  logic               pop,
	output tgle_pkg::q_entry_t head,
	output tgle_pkg::q_stat_t  stat
);
	import tgle_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	q_entry_t        mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		stat.full |-> !push || pop)
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		stat.empty |-> !pop)
		else $error("queue pop while empty");
`endif
endmodule

// ===== rtl/tgle_back.sv =====
module tgle_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tgle_pkg::cfg_t       cfg,
	input  tgle_pkg::q_entry_t   head,
	input  tgle_pkg::q_stat_t    q_stat,
	output logic                 pop,
	output logic                 out_valid,
	output tgle_pkg::glyph_item_t out_data,
	input  logic                 out_ready
);
	import tgle_pkg::*;

	logic        out_valid_q;
	glyph_item_t out_q;
	logic        page_pend_q;    // rectangle of head already sent, texpage left
	logic        load, emit, send_glyph;
	glyph_item_t nxt;

	assign load       = !out_valid_q || out_ready;
	assign emit       = load && !q_stat.empty;
	assign send_glyph = head.has_glyph && !page_pend_q;
	assign pop        = emit && !(send_glyph && head.has_page);

	always_comb begin
		nxt          = '0;
		nxt.slot_tag = head.slot_tag;
		if (send_glyph) begin
			nxt.cmd_kind     = CMD_GLYPH;
			nxt.screen_x     = head.screen_x;
			nxt.screen_y     = head.screen_y;
			nxt.tex_u        = head.tex_u;
			nxt.tex_v        = head.tex_v;
			nxt.clut_word    = cfg.palette_id;
			nxt.glyph_width  = head.glyph_width;
			nxt.glyph_height = GLYPH_HEIGHT;
			nxt.run_end      = !head.has_page;
		end else begin
			nxt.cmd_kind  = CMD_PAGE;
			nxt.page_word = cfg.texture_page;
			nxt.run_end   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			page_pend_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= !q_stat.empty;
			if (emit)
				page_pend_q <= send_glyph && head.has_page;
		end
	end

	always_ff @(posedge clk) begin
		if (emit)
			out_q <= nxt;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef ASSERT_OFF
	a_pend_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		page_pend_q |-> !q_stat.empty && head.has_page)
		else $error("pending texpage without queued entry");
`endif
endmodule

// ===== rtl/text_glyph_layout_engine_unit.sv =====
// Text glyph layout engine. Characters of a string enter one item per clock on
// chars while the queue is not full; each printable character leaves as one
// textured rectangle on glyphs, placed at the cursor, with sheet coordinates
// taken from the font base plus the built-in 95-glyph table (modulo 256). Tab,
// newline and space only move the cursor; codes 0x80-0xFF and stray control
// codes draw the invalid glyph. An item flagged last_char is followed by a
// texpage item, and run_end marks the final result of each character. Results
// leave one per cycle while glyphs.ready holds, so a last character (two
// results) backs up the output side; the QUEUE_DEPTH-entry queue between the
// classifier and the result sequencer absorbs that. A result passes its queue
// entry and then the output register before it is valid. Configuration is
// written through cfg_we/cfg_idx/cfg_wdata; the user must do so only while the
// block is idle, which the block does not enforce. Unknown indexes are ignored.
module text_glyph_layout_engine_unit #(
	parameter int QUEUE_DEPTH = tgle_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [15:0] cfg_wdata,
	tgle_char_if.sink   chars,
	tgle_glyph_if.source glyphs
);
	import tgle_pkg::*;

	cfg_t     cfg_q;
	q_stat_t  q_stat;
	q_entry_t push_entry, head;
	logic     push, pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sheet_u       <= '0;
			cfg_q.sheet_v       <= '0;
			cfg_q.palette_id    <= '0;
			cfg_q.texture_page  <= '0;
			cfg_q.tab_stop_log2 <= 3'd5;
			cfg_q.line_step     <= 8'd10;
			cfg_q.blank_step    <= 8'd4;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_SHEET_U:       cfg_q.sheet_u       <= cfg_wdata[7:0];
				CFG_SHEET_V:       cfg_q.sheet_v       <= cfg_wdata[7:0];
				CFG_PALETTE_ID:    cfg_q.palette_id    <= cfg_wdata;
				CFG_TEXTURE_PAGE:  cfg_q.texture_page  <= cfg_wdata;
				CFG_TAB_STOP_LOG2: cfg_q.tab_stop_log2 <= cfg_wdata[2:0];
				CFG_LINE_STEP:     cfg_q.line_step     <= cfg_wdata[7:0];
				CFG_BLANK_STEP:    cfg_q.blank_step    <= cfg_wdata[7:0];
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	// front: cursor tracking and classification, one character per cycle while the queue is not full
	tgle_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (chars.valid),
		.in_data    (chars.data),
		.in_ready   (chars.ready),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	// work queue; characters that only move the cursor enter it only when flagged last_char
	tgle_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.stat       (q_stat)
	);

	// back: expands each entry into rectangle and/or texpage results
	tgle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (glyphs.valid),
		.out_data  (glyphs.data),
		.out_ready (glyphs.ready)
	);

`ifndef ASSERT_OFF
	a_last_queued: assert property (@(posedge clk) disable iff (!arst_n)
		chars.valid && chars.ready && chars.data.last_char |=> !q_stat.empty)
		else $error("last character produced no queued work");
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !chars.ready)
		else $error("input ready while queue full");
`endif
endmodule

// ===== sim/tgle_layout_monitor.sv =====
module tgle_layout_monitor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [15:0] cfg_wdata,
	tgle_char_if        chars,
	tgle_glyph_if       glyphs,
	output int          mismatches,
	output int          outstanding,
	output int          glyphs_seen,
	output int          pages_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import tgle_pkg::*;

	localparam int MAX_REPORTS = 10;

	cfg_t          regs;
	logic [15:0]   pen_x;
	logic [15:0]   pen_y;
	logic [15:0]   margin_x;
	glyph_item_t   due_glyphs[$];
	int            bad;
	int            n_glyph;
	int            n_page;

	// advance the pen for one character and queue the rectangle and texpage results it should produce
	task automatic lay_out_char(input char_item_t c);
		glyph_item_t r;
		logic [6:0]  g;
		logic [6:0]  p;
		logic [15:0] span;
		if (c.first_char) begin
			pen_x = c.origin_x;
			pen_y = c.origin_y;
			margin_x = c.origin_x;
		end
		case (c.char_code)
			CODE_TAB: begin
				span = 16'd1 << regs.tab_stop_log2;
				pen_x = (pen_x + span - 16'd1) & ~(span - 16'd1);
			end
			CODE_NEWLINE: begin
				pen_x = margin_x;
				pen_y = pen_y + {8'd0, regs.line_step};
			end
			CODE_SPACE: pen_x = pen_x + {8'd0, regs.blank_step};
			default: begin
				if (c.char_code >= CODE_FIRST_GLYPH && c.char_code <= CODE_LAST_GLYPH)
					g = 7'(c.char_code - CODE_FIRST_GLYPH);
				else
					g = INVALID_GLYPH;
				p = g + 7'd1;
				r = '0;
				r.cmd_kind = CMD_GLYPH;
				r.screen_x = pen_x;
				r.screen_y = pen_y;
				r.tex_u = regs.sheet_u + 8'(p[3:0] * 6);
				r.tex_v = regs.sheet_v + 8'(p[6:4] * 9);
				r.clut_word = regs.palette_id;
				r.glyph_width = GLYPH_W[g];
				r.glyph_height = GLYPH_HEIGHT;
				r.slot_tag = c.depth_slot;
				r.run_end = !c.last_char;
				due_glyphs.push_back(r);
				pen_x = pen_x + {13'd0, GLYPH_W[g]};
			end
		endcase
		if (c.last_char) begin
			r = '0;
			r.cmd_kind = CMD_PAGE;
			r.page_word = regs.texture_page;
			r.slot_tag = c.depth_slot;
			r.run_end = 1'b1;
			due_glyphs.push_back(r);
		end
	endtask

	function automatic string wrong_fields(input glyph_item_t e, input glyph_item_t a);
		string s;
		s = "";
		if (a.cmd_kind !== e.cmd_kind) s = {s, " cmd_kind"};
		if (a.screen_x !== e.screen_x) s = {s, " screen_x"};
		if (a.screen_y !== e.screen_y) s = {s, " screen_y"};
		if (a.tex_u !== e.tex_u) s = {s, " tex_u"};
		if (a.tex_v !== e.tex_v) s = {s, " tex_v"};
		if (a.clut_word !== e.clut_word) s = {s, " clut_word"};
		if (a.glyph_width !== e.glyph_width) s = {s, " glyph_width"};
		if (a.glyph_height !== e.glyph_height) s = {s, " glyph_height"};
		if (a.page_word !== e.page_word) s = {s, " page_word"};
		if (a.slot_tag !== e.slot_tag) s = {s, " slot_tag"};
		if (a.run_end !== e.run_end) s = {s, " run_end"};
		return s;
	endfunction

	function automatic string show(input glyph_item_t r);
		return $sformatf("kind=%0d x=%0d y=%0d u=%0d v=%0d clut=%h w=%0d h=%0d page=%h slot=%h end=%0d",
			r.cmd_kind, r.screen_x, r.screen_y, r.tex_u, r.tex_v, r.clut_word,
			r.glyph_width, r.glyph_height, r.page_word, r.slot_tag, r.run_end);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		glyph_item_t want;
		string diff;
		if (!arst_n) begin
			regs = '0;
			regs.tab_stop_log2 = 3'd5;
			regs.line_step = 8'd10;
			regs.blank_step = 8'd4;
			pen_x = '0;
			pen_y = '0;
			margin_x = '0;
			due_glyphs.delete();
			bad = 0;
			n_glyph = 0;
			n_page = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_idx))
					CFG_SHEET_U:       regs.sheet_u = cfg_wdata[7:0];
					CFG_SHEET_V:       regs.sheet_v = cfg_wdata[7:0];
					CFG_PALETTE_ID:    regs.palette_id = cfg_wdata;
					CFG_TEXTURE_PAGE:  regs.texture_page = cfg_wdata;
					CFG_TAB_STOP_LOG2: regs.tab_stop_log2 = cfg_wdata[2:0];
					CFG_LINE_STEP:     regs.line_step = cfg_wdata[7:0];
					CFG_BLANK_STEP:    regs.blank_step = cfg_wdata[7:0];
					default: ;
				endcase
			end
			// results are registered and never leave in the cycle their character is accepted, so check before predicting
			if (glyphs.valid && glyphs.ready) begin
				if (glyphs.data.cmd_kind == CMD_PAGE)
					n_page++;
				else
					n_glyph++;
				if (due_glyphs.size() == 0) begin
					bad++;
					if (bad <= MAX_REPORTS)
						$display("%t unexpected result: %s", $realtime, show(glyphs.data));
				end else begin
					want = due_glyphs.pop_front();
					diff = wrong_fields(want, glyphs.data);
					if (diff != "") begin
						bad++;
						if (bad <= MAX_REPORTS)
							$display("%t mismatch in%s\n  expected %s\n  actual   %s",
								$realtime, diff, show(want), show(glyphs.data));
					end
				end
			end
			if (chars.valid && chars.ready)
				lay_out_char(chars.data);
		end
		mismatches <= bad;
		outstanding <= due_glyphs.size();
		glyphs_seen <= n_glyph;
		pages_seen <= n_page;
	end

endmodule

// ===== sim/text_glyph_layout_engine_unit_tb.sv =====
module text_glyph_layout_engine_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tgle_pkg::*;

	// index with no register behind it; writes there must be dropped
	localparam logic [2:0] CFG_UNMAPPED = 3'd7;
	localparam int RANDOM_ITEMS = 1400;
	localparam int NUM_PHASES = 8;
	localparam int LONG_HOLD = 48;
	// a result passes the queue and the output register after its character; a char with no result may be in flight
	localparam int DRAIN_CYCLES = 6;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [15:0] cfg_wdata;

	tgle_char_if  chars_if ();
	tgle_glyph_if glyphs_if ();

	int mismatches;
	int outstanding;
	int glyphs_seen;
	int pages_seen;

	// pacing knobs for the sender (gap_max) and the receiver (stall_max, hold_long)
	int gap_max;
	int stall_max;
	bit hold_long;
	int chars_sent;
	int settings_used;

	text_glyph_layout_engine_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.chars     (chars_if),
		.glyphs    (glyphs_if)
	);

	tgle_layout_monitor u_monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.chars       (chars_if),
		.glyphs      (glyphs_if),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.glyphs_seen (glyphs_seen),
		.pages_seen  (pages_seen)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// hard stop well beyond the slowest legal run
	initial begin
		#5ms;
		$display("FAILURE");
		$finish;
	end

	// one item: optional idle gap, then hold valid until the block takes it
	task automatic send_char(input char_item_t c);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			chars_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chars_if.valid <= 1'b1;
		chars_if.data <= c;
		do @(posedge clk); while (!chars_if.ready);
		chars_sent++;
	endtask

	function automatic char_item_t make_char(input logic [7:0] code, input logic first,
			input logic [15:0] ox, input logic [15:0] oy, input logic [15:0] slot,
			input logic last);
		char_item_t c;
		c.char_code = code;
		c.first_char = first;
		c.origin_x = ox;
		c.origin_y = oy;
		c.depth_slot = slot;
		c.last_char = last;
		return c;
	endfunction

	// mostly printable text, with cursor moves and the invalid-glyph cases mixed in
	function automatic logic [7:0] pick_code();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 8'($urandom_range(8'h21, 8'h7E));
		if (r < 67) return CODE_SPACE;
		if (r < 74) return CODE_TAB;
		if (r < 81) return CODE_NEWLINE;
		if (r < 86) return CODE_LAST_GLYPH;
		if (r < 93) return 8'($urandom_range(8'h80, 8'hFF));
		return 8'($urandom_range(8'h00, 8'h1F));
	endfunction

	// well-formed: first flag on the opening char, last flag on the closing one;
	// broken strings scatter both flags at random
	task automatic send_string(input bit broken);
		int         len;
		logic [15:0] slot;
		char_item_t c;
		len = $urandom_range(1, 12);
		slot = 16'($urandom);
		for (int i = 0; i < len; i++) begin
			c = make_char(pick_code(), i == 0, 16'($urandom), 16'($urandom), slot,
				i == len - 1);
			if (broken) begin
				c.first_char = $urandom_range(0, 3) == 0;
				c.last_char = $urandom_range(0, 3) == 0;
				c.depth_slot = 16'($urandom);
			end
			send_char(c);
		end
	endtask

	// wait for every predicted result, then let a result-less char clear the pipe
	task automatic settle();
		chars_if.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// leaves cfg_we high; load_config drops it after the last write
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= v;
		@(posedge clk);
	endtask

	// unused upper data bits carry junk; the block must mask them
	task automatic load_config(input cfg_t c);
		write_reg(CFG_SHEET_U, {8'($urandom), c.sheet_u});
		write_reg(CFG_SHEET_V, {8'($urandom), c.sheet_v});
		write_reg(CFG_PALETTE_ID, c.palette_id);
		write_reg(CFG_TEXTURE_PAGE, c.texture_page);
		write_reg(CFG_TAB_STOP_LOG2, {13'($urandom), c.tab_stop_log2});
		write_reg(CFG_LINE_STEP, {8'($urandom), c.line_step});
		write_reg(CFG_BLANK_STEP, {8'($urandom), c.blank_step});
		write_reg(CFG_UNMAPPED, 16'($urandom));
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	// receiver: random back-pressure per result, plus one long hold on request
	initial begin
		int stall;
		glyphs_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_long) begin
				stall = LONG_HOLD;
				hold_long = 1'b0;
			end else begin
				stall = $urandom_range(0, stall_max);
			end
			if (stall > 0) begin
				glyphs_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			glyphs_if.ready <= 1'b1;
			do @(posedge clk); while (!glyphs_if.valid);
		end
	end

	// stimulus and verdict
	initial begin
		cfg_t setting;
		int   phase_start;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= '0;
		cfg_wdata <= '0;
		chars_if.valid <= 1'b0;
		chars_if.data <= '0;
		gap_max = 0;
		stall_max = 0;
		hold_long = 1'b0;
		chars_sent = 0;
		settings_used = 1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pass at reset settings: tab 32, line 10, blank 4
		gap_max = 2;
		stall_max = 2;
		// start at the most negative column, bottom row
		send_char(make_char(CODE_FIRST_GLYPH, 1'b1, 16'h8000, 16'h7FFF, 16'h0000, 1'b0));
		send_char(make_char(8'h7E, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
		// invalid-glyph code itself, stray controls, high codes
		send_char(make_char(CODE_LAST_GLYPH, 1'b0, 16'h0000, 16'h0000, 16'h1234, 1'b0));
		send_char(make_char(8'h00, 1'b0, 16'h5555, 16'hAAAA, 16'h0001, 1'b0));
		send_char(make_char(8'h1F, 1'b0, 16'hAAAA, 16'h5555, 16'h8000, 1'b0));
		send_char(make_char(8'h80, 1'b0, 16'h0000, 16'h0000, 16'h7FFF, 1'b0));
		send_char(make_char(8'hFF, 1'b0, 16'h0000, 16'h0000, 16'hFFFE, 1'b0));
		send_char(make_char(CODE_SPACE, 1'b0, 16'h0000, 16'h0000, 16'h0002, 1'b0));
		// newline wraps the row past the bottom
		send_char(make_char(CODE_NEWLINE, 1'b0, 16'h0000, 16'h0000, 16'h0003, 1'b0));
		send_char(make_char(CODE_TAB, 1'b0, 16'h0000, 16'h0000, 16'h0004, 1'b0));
		// tab from a negative column rounds up to the next stop
		send_char(make_char(CODE_TAB, 1'b1, 16'hFFFB, 16'h0000, 16'h0005, 1'b0));
		send_char(make_char(CODE_FIRST_GLYPH, 1'b1, 16'hFFDB, 16'hFFF0, 16'h0006, 1'b0));
		send_char(make_char(CODE_TAB, 1'b0, 16'h0000, 16'h0000, 16'h0007, 1'b0));
		// glyph plus texpage, cursor wraps past the largest column
		send_char(make_char(8'h41, 1'b1, 16'h7FFE, 16'hFFFF, 16'h0008, 1'b1));
		send_char(make_char(CODE_TAB, 1'b0, 16'h0000, 16'h0000, 16'h0009, 1'b0));
		// cursor moves that end a string give the texpage alone
		send_char(make_char(CODE_SPACE, 1'b0, 16'h0000, 16'h0000, 16'h000A, 1'b1));
		send_char(make_char(CODE_NEWLINE, 1'b0, 16'h0000, 16'h0000, 16'h000B, 1'b1));
		send_char(make_char(CODE_TAB, 1'b0, 16'h0000, 16'h0000, 16'h000C, 1'b1));
		// one-character strings
		send_char(make_char(8'h57, 1'b1, 16'h0010, 16'h0020, 16'h000D, 1'b1));
		send_char(make_char(8'h01, 1'b1, 16'hFFFF, 16'h8000, 16'h000E, 1'b1));
		settle();

		// random pass: each phase has its own register setting and pacing
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			if (phase == 0) begin
				setting = '0;
			end else if (phase == 1) begin
				setting = '1;
			end else begin
				setting.sheet_u = 8'($urandom);
				setting.sheet_v = 8'($urandom);
				setting.palette_id = 16'($urandom);
				setting.texture_page = 16'($urandom);
				setting.tab_stop_log2 = 3'($urandom);
				setting.line_step = 8'($urandom);
				setting.blank_step = 8'($urandom);
			end
			load_config(setting);

			gap_max = (phase % 3 == 0) ? 0 : 8;
			stall_max = (phase % 4 == 1) ? 0 : 8;
			// back-to-back chars against a long output hold: the queue must fill
			if (phase % 3 == 0 && phase > 0)
				hold_long = 1'b1;

			phase_start = chars_sent;
			while (chars_sent - phase_start < RANDOM_ITEMS / NUM_PHASES)
				send_string($urandom_range(0, 9) == 0);
			// sender waits for every result before the next setting
			settle();
		end

		$display("Sent %0d characters under %0d register settings,", chars_sent, settings_used);
		$display("checked %0d glyph rectangles and %0d texpage commands.",
			glyphs_seen, pages_seen);
		if (mismatches == 0 && outstanding == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
